@@ rtl/bpa_pkg.sv @@
// Shared types and constants of the buddy page allocator.
// Depends on nothing; every other file imports it.
package bpa_pkg;

  localparam int unsigned NumPages  = 65536;
  localparam int unsigned MaxOrder  = 10;
  localparam int unsigned Levels    = MaxOrder + 1;
  localparam int unsigned PageW     = $clog2(NumPages);
  localparam int unsigned LinkW     = PageW + 1;
  localparam int unsigned OrdW      = 4;
  localparam int unsigned MarkW     = 5;
  localparam int unsigned LvlW      = $clog2(Levels);
  localparam logic [LinkW-1:0] Nil  = LinkW'(NumPages);
  localparam logic [16:0] CountMax  = 17'h1FFFF;

  localparam logic [1:0] ReqAlloc = 2'd0;
  localparam logic [1:0] ReqFree  = 2'd1;
  localparam logic [1:0] ReqAdd   = 2'd2;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StOrder = 2'd1;
  localparam logic [1:0] StOom   = 2'd2;
  localparam logic [1:0] StPool  = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  order;
    logic [15:0] page;
    logic [16:0] end_page;
  } req_t;

  typedef struct packed {
    logic [15:0] alloc_page;
    logic [1:0]  status;
    logic [16:0] managed_pages;
  } rsp_t;

  // Datapath micro-operations issued by the controller.
  typedef enum logic [3:0] {
    OpNone,
    OpLoad,      // latch request fields
    OpMarkRd,    // read free_mark at addr_q
    OpLinkRd,    // read next_link at addr_q
    OpPush,      // push addr_q at ord_q
    OpPopHead,   // head[ord_q] <= rdata link; clear mark
    OpFixLink,   // link[prev_q] <= link read; clear mark
    OpStep,      // advance cursor
    OpClear      // clear one mark entry after reset
  } op_e;

  typedef struct packed {
    logic [MarkW-1:0]  mark;
    logic [LinkW-1:0]  link;
    logic [LinkW-1:0]  head;
  } sts_t;

endpackage

@@ rtl/bpa_datapath.sv @@
// Memories and list heads of the buddy page allocator.
// Depends on bpa_pkg.
module bpa_datapath (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  bpa_pkg::op_e             op_i,
  input  logic [bpa_pkg::PageW-1:0] addr_i,
  input  logic [bpa_pkg::PageW-1:0] prev_i,
  input  logic [bpa_pkg::LvlW-1:0]  lvl_i,
  output bpa_pkg::sts_t            sts_o
);
  import bpa_pkg::*;

  logic [LinkW-1:0] link_mem [NumPages];
  logic [MarkW-1:0] mark_mem [NumPages];
  logic [LinkW-1:0] head_q [Levels];
  logic [LinkW-1:0] link_rd_q;
  logic [MarkW-1:0] mark_rd_q;

  // Read and write the link memory.
  always_ff @(posedge clk_i) begin
    if (op_i == OpLinkRd) begin
      link_rd_q <= link_mem[addr_i];
    end
    if (op_i == OpPush) begin
      link_mem[addr_i] <= head_q[lvl_i];
    end else if (op_i == OpFixLink) begin
      link_mem[prev_i] <= link_rd_q;
    end
  end

  // Mark memory; the clearing pass after reset zeroes every entry.
  always_ff @(posedge clk_i) begin
    if (op_i == OpMarkRd) begin
      mark_rd_q <= mark_mem[addr_i];
    end
    if (op_i == OpPush) begin
      mark_mem[addr_i] <= MarkW'(lvl_i) + MarkW'(1);
    end else if (op_i == OpPopHead || op_i == OpFixLink || op_i == OpClear) begin
      mark_mem[addr_i] <= '0;
    end
  end

  // Update list heads on push and pop.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Levels; i++) head_q[i] <= Nil;
    end else begin
      if (op_i == OpPush) begin
        head_q[lvl_i] <= LinkW'(addr_i);
      end else if (op_i == OpPopHead) begin
        head_q[lvl_i] <= link_rd_q;
      end
    end
  end

  assign sts_o.mark = mark_rd_q;
  assign sts_o.link = link_rd_q;
  assign sts_o.head = head_q[lvl_i];

endmodule

@@ rtl/bpa_ctrl.sv @@
// Sequencer for allocate, free and add-range of the buddy page allocator.
// Depends on bpa_pkg; drives bpa_datapath by micro-operations.
module bpa_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  bpa_pkg::req_t             req_i,
  output logic                      busy_o,
  output bpa_pkg::op_e              op_o,
  output logic [bpa_pkg::PageW-1:0] addr_o,
  output logic [bpa_pkg::PageW-1:0] prev_o,
  output logic [bpa_pkg::LvlW-1:0]  lvl_o,
  output logic [bpa_pkg::LinkW-1:0] cnt_add_o,
  output logic                      cnt_en_o,
  input  bpa_pkg::sts_t             sts_i,
  output logic                      done_o,
  output logic [15:0]               page_o,
  output logic [1:0]                status_o
);
  import bpa_pkg::*;

  localparam logic [4:0] SIdle    = 5'd0;
  localparam logic [4:0] SDecode  = 5'd1;
  localparam logic [4:0] SScan    = 5'd2;
  localparam logic [4:0] SAHead   = 5'd3;
  localparam logic [4:0] SAPop    = 5'd4;
  localparam logic [4:0] SASplit  = 5'd5;
  localparam logic [4:0] SAChk    = 5'd6;
  localparam logic [4:0] SFMark   = 5'd7;
  localparam logic [4:0] SFChk    = 5'd8;
  localparam logic [4:0] SFBud    = 5'd9;
  localparam logic [4:0] SFBudChk = 5'd10;
  localparam logic [4:0] SUnHead  = 5'd11;
  localparam logic [4:0] SUnWalk  = 5'd12;
  localparam logic [4:0] SUnChk   = 5'd13;
  localparam logic [4:0] SUnFix   = 5'd14;
  localparam logic [4:0] SFPush   = 5'd15;
  localparam logic [4:0] SRBlk    = 5'd16;
  localparam logic [4:0] SRChk    = 5'd17;
  localparam logic [4:0] SDone    = 5'd18;
  localparam logic [4:0] SUnPop   = 5'd19;
  localparam logic [4:0] SUnRd    = 5'd20;
  localparam logic [4:0] SClear   = 5'd21;

  logic [4:0]       state_q, state_d;
  req_t             req_q;
  logic [LinkW-1:0] base_q, base_d;   // cursor page, add base or merge base
  logic [LinkW-1:0] top_q, top_d;
  logic [OrdW-1:0]  cur_q, cur_d;
  logic [LinkW-1:0] walk_q, walk_d;   // list walk cursor
  logic [LinkW-1:0] bud_q, bud_d;
  logic [15:0]      res_q, res_d;
  logic [1:0]       st_q, st_d;
  logic [OrdW-1:0]  rord;             // chosen order of add block
  logic [LinkW-1:0] rsize;
  logic [LinkW:0]   fend;
  logic [LinkW-1:0] half;

  // Largest aligned block at base that fits below top.
  always_comb begin
    rord = '0;
    for (int k = 1; k <= MaxOrder; k++) begin
      if (rord == OrdW'(k - 1) && (top_q - base_q) >= (LinkW'(1) << k) &&
          (base_q & ((LinkW'(1) << k) - LinkW'(1))) == '0) begin
        rord = OrdW'(k);
      end
    end
  end
  assign rsize = LinkW'(1) << rord;
  assign fend  = (LinkW+1)'(req_q.page) + ((LinkW+1)'(1) << req_q.order);
  assign half  = base_q + (LinkW'(1) << (cur_q - OrdW'(1)));

  always_comb begin
    state_d = state_q; base_d = base_q; top_d = top_q; cur_d = cur_q;
    walk_d = walk_q; bud_d = bud_q; res_d = res_q; st_d = st_q;
    op_o = OpNone; addr_o = base_q[PageW-1:0]; prev_o = walk_q[PageW-1:0];
    lvl_o = LvlW'(cur_q); cnt_add_o = rsize; cnt_en_o = 1'b0;
    unique case (state_q)
      // Zero the mark memory one entry per cycle.
      SClear: begin
        op_o = OpClear; base_d = base_q + LinkW'(1);
        if (base_q == LinkW'(NumPages - 1)) state_d = SIdle;
      end
      SIdle: begin
        if (start_i) state_d = SDecode;
      end
      SDecode: begin
        res_d = '0; st_d = StOk; cur_d = req_q.order;
        base_d = LinkW'(req_q.page);
        top_d = (req_q.end_page > 17'(NumPages)) ? Nil : LinkW'(req_q.end_page);
        unique case (req_q.req_type)
          ReqAlloc: begin
            if (req_q.order > OrdW'(MaxOrder)) begin st_d = StOrder; state_d = SDone; end
            else state_d = SScan;
          end
          ReqFree: begin
            if (req_q.order > OrdW'(MaxOrder)) begin st_d = StOrder; state_d = SDone; end
            else if (fend > (LinkW+1)'(NumPages) ||
                     (LinkW'(req_q.page) & ((LinkW'(1) << req_q.order) - LinkW'(1))) != '0)
              begin st_d = StPool; state_d = SDone; end
            else state_d = SFMark;
          end
          ReqAdd: begin
            if (LinkW'(req_q.page) >= Nil) begin st_d = StPool; state_d = SDone; end
            else state_d = SRBlk;
          end
          default: state_d = SDone;
        endcase
      end
      // Find lowest non-empty order.
      SScan: begin
        if (cur_q > OrdW'(MaxOrder)) begin st_d = StOom; state_d = SDone; end
        else if (sts_i.head >= Nil) cur_d = cur_q + OrdW'(1);
        else begin base_d = sts_i.head; state_d = SAHead; end
      end
      SAHead: begin
        op_o = OpLinkRd; state_d = SAPop;
      end
      SAPop: begin
        op_o = OpPopHead; res_d = base_q[15:0]; state_d = SASplit;
      end
      // Split down, one upper half per step.
      SASplit: begin
        if (cur_q == req_q.order) state_d = SDone;
        else if (half >= Nil) cur_d = cur_q - OrdW'(1);
        else begin op_o = OpMarkRd; addr_o = half[PageW-1:0]; state_d = SAChk; end
      end
      SAChk: begin
        addr_o = half[PageW-1:0]; lvl_o = LvlW'(cur_q - OrdW'(1));
        if (sts_i.mark == '0) op_o = OpPush;
        cur_d = cur_q - OrdW'(1); state_d = SASplit;
      end
      SFMark: begin
        op_o = OpMarkRd; state_d = SFChk;
      end
      SFChk: begin
        state_d = (sts_i.mark == '0) ? SFBud : SDone;
      end
      SFBud: begin
        bud_d = base_q ^ (LinkW'(1) << cur_q);
        if (cur_q >= OrdW'(MaxOrder) || (base_q ^ (LinkW'(1) << cur_q)) >= Nil)
          state_d = SFPush;
        else begin
          op_o = OpMarkRd; addr_o = PageW'(base_q ^ (LinkW'(1) << cur_q));
          state_d = SFBudChk;
        end
      end
      SFBudChk: begin
        if (sts_i.mark != MarkW'(cur_q) + MarkW'(1)) state_d = SFPush;
        else state_d = SUnHead;
      end
      // Unlink buddy from its list.
      SUnHead: begin
        addr_o = bud_q[PageW-1:0]; op_o = OpLinkRd;
        if (sts_i.head == bud_q) begin walk_d = '0; state_d = SUnPop; end
        else begin walk_d = sts_i.head; state_d = SUnRd; end
      end
      SUnPop: begin
        addr_o = bud_q[PageW-1:0]; op_o = OpPopHead; state_d = SUnFix;
      end
      SUnRd: begin
        if (walk_q >= Nil) state_d = SUnFix;
        else begin op_o = OpLinkRd; addr_o = walk_q[PageW-1:0]; state_d = SUnChk; end
      end
      SUnChk: begin
        if (sts_i.link == bud_q) begin
          op_o = OpLinkRd; addr_o = bud_q[PageW-1:0]; state_d = SUnWalk;
        end else begin walk_d = sts_i.link; state_d = SUnRd; end
      end
      SUnWalk: begin
        op_o = OpFixLink; addr_o = bud_q[PageW-1:0]; state_d = SUnFix;
      end
      SUnFix: begin
        // Clear the mark when the walk found nothing; then merge up.
        if (walk_q >= Nil) begin
          op_o = OpFixLink; addr_o = bud_q[PageW-1:0]; prev_o = bud_q[PageW-1:0];
        end
        if (bud_q < base_q) base_d = bud_q;
        cur_d = cur_q + OrdW'(1); walk_d = '0; state_d = SFBud;
      end
      SFPush: begin
        op_o = OpPush; state_d = SDone;
      end
      // Add range: one block per pass.
      SRBlk: begin
        if (base_q >= top_q) state_d = SDone;
        else begin op_o = OpMarkRd; state_d = SRChk; end
      end
      SRChk: begin
        lvl_o = LvlW'(rord);
        if (sts_i.mark == '0) begin
          op_o = OpPush; cnt_en_o = 1'b1;
        end
        cur_d = rord; state_d = SRBlk; base_d = base_q + rsize;
      end
      SDone: begin
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SIdle && start_i) req_q <= req_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear; base_q <= '0; top_q <= '0; cur_q <= '0;
      walk_q <= '0; bud_q <= '0; res_q <= '0; st_q <= '0;
    end else begin
      state_q <= state_d; base_q <= base_d; top_q <= top_d; cur_q <= cur_d;
      walk_q <= walk_d; bud_q <= bud_d; res_q <= res_d; st_q <= st_d;
    end
  end

  assign busy_o   = state_q != SIdle;
  assign done_o   = state_q == SDone;
  assign page_o   = res_q;
  assign status_o = st_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("done lasted two cycles");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SIdle && start_i) |=> state_q == SDecode)
    else $error("start not taken");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != StOk) |-> page_o == '0)
    else $error("failed request returned a page");
endmodule

@@ rtl/bpa_counter.sv @@
// Count of managed pages, bumped for each block an add-range pushes.
// Depends on bpa_pkg.
module bpa_counter (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bpa_pkg::op_e              op_i,
  input  logic                      add_i,
  input  logic [bpa_pkg::LinkW-1:0] size_i,
  output logic [16:0]               count_o
);
  import bpa_pkg::*;

  logic [16:0] count_q;
  logic [17:0] sum;

  assign sum = {1'b0, count_q} + 18'(size_i);

  // Saturate at the field maximum.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (add_i && op_i == OpPush) begin
      count_q <= (sum > 18'(CountMax)) ? CountMax : sum[16:0];
    end
  end

  assign count_o = count_q;
endmodule

@@ rtl/buddy_page_allocator.sv @@
// Buddy page allocator: controller, memory datapath and page counter.
// Time from accept to strobe grows, for allocate, with each empty order skipped
// and each split; for free, with each merge and each link walked when the buddy
// is not a list head; for add-range, with each block. One item at a time.
// Reset: lists empty, count zero; a mark clearing pass over all pages holds busy high.
// Results show for one cycle on done_o; the receiver cannot stall.
module buddy_page_allocator (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  bpa_pkg::req_t   req_i,
  output logic            done_o,
  output bpa_pkg::rsp_t   rsp_o
);
  import bpa_pkg::*;

  op_e              op;
  logic [PageW-1:0] addr, prev;
  logic [LvlW-1:0]  lvl;
  logic [LinkW-1:0] cnt_add;
  logic             cnt_en;
  sts_t             sts;
  logic [16:0]      count;
  logic [15:0]      page;
  logic [1:0]       status;

  bpa_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .req_i, .busy_o(busy),
    .op_o(op), .addr_o(addr), .prev_o(prev), .lvl_o(lvl), .cnt_add_o(cnt_add),
    .cnt_en_o(cnt_en), .sts_i(sts), .done_o, .page_o(page), .status_o(status)
  );

  bpa_datapath u_dp (
    .clk_i, .rst_ni, .op_i(op), .addr_i(addr), .prev_i(prev), .lvl_i(lvl),
    .sts_o(sts)
  );

  bpa_counter u_cnt (
    .clk_i, .rst_ni, .op_i(op), .add_i(cnt_en), .size_i(cnt_add), .count_o(count)
  );

  assign rsp_o.alloc_page    = page;
  assign rsp_o.status        = status;
  assign rsp_o.managed_pages = count;
endmodule

@@ tb/buddy_page_allocator_test.sv @@
// Self-checking testbench for buddy_page_allocator: directed and random items.
// An in-bench model of the free lists predicts each result; depends on bpa_pkg.
module buddy_page_allocator_test;
  import bpa_pkg::*;

  localparam logic [1:0] ReqNone = 2'd3;
  localparam int         WatchLimit = 400000;

  // Free-list model and queue of expected results
  class alloc_scoreboard;
    int unsigned heads[Levels];
    int unsigned links[NumPages];
    int unsigned marks[NumPages];
    int unsigned count;
    rsp_t        expected_q[$];
    int          errors;
    int          results;

    function new();
      foreach (heads[i]) heads[i] = NumPages;
      foreach (marks[i]) marks[i] = 0;
      count = 0;
      errors = 0;
      results = 0;
    endfunction

    function void push_blk(int unsigned p, int unsigned o);
      links[p] = heads[o];
      heads[o] = p;
      marks[p] = o + 1;
    endfunction

    function void unlink_blk(int unsigned p, int unsigned o);
      int unsigned cur;
      int unsigned nx;
      int unsigned steps;
      if (heads[o] == p) begin
        heads[o] = links[p];
      end else begin
        cur = heads[o];
        steps = 0;
        while (cur < NumPages && steps < NumPages) begin
          nx = links[cur];
          if (nx == p) begin
            links[cur] = links[p];
            break;
          end
          cur = nx;
          steps++;
        end
      end
      marks[p] = 0;
    endfunction

    // Apply one accepted item and queue its result; return the prediction
    function rsp_t note_item(req_t r);
      rsp_t        e;
      int unsigned cur, p, b, o, half, base, top, sz, nsz;
      longint unsigned s;
      e = '0;
      case (r.req_type)
        ReqAlloc: begin
          if (r.order > MaxOrder) begin
            e.status = StOrder;
          end else begin
            cur = r.order;
            while (cur <= MaxOrder && heads[cur] >= NumPages) cur++;
            if (cur > MaxOrder) begin
              e.status = StOom;
            end else begin
              p = heads[cur];
              unlink_blk(p, cur);
              while (cur > r.order) begin
                cur--;
                half = p + (1 << cur);
                if (half < NumPages && marks[half] == 0) push_blk(half, cur);
              end
              e.alloc_page = p[15:0];
            end
          end
        end
        ReqFree: begin
          if (r.order > MaxOrder) begin
            e.status = StOrder;
          end else if (int'(r.page) + (1 << r.order) > NumPages ||
                       (r.page & ((1 << r.order) - 1)) != 0) begin
            e.status = StPool;
          end else if (marks[r.page] == 0) begin
            p = r.page;
            o = r.order;
            while (o < MaxOrder) begin
              b = p ^ (1 << o);
              if (b >= NumPages || marks[b] != o + 1) break;
              unlink_blk(b, o);
              if (b < p) p = b;
              o++;
            end
            push_blk(p, o);
          end
        end
        ReqAdd: begin
          base = r.page;
          top = (r.end_page > NumPages) ? NumPages : r.end_page;
          while (base < top) begin
            o = 0;
            while (o < MaxOrder) begin
              nsz = 1 << (o + 1);
              if (nsz > top - base || (base & (nsz - 1)) != 0) break;
              o++;
            end
            sz = 1 << o;
            if (marks[base] == 0) begin
              push_blk(base, o);
              s = longint'(count) + sz;
              count = (s > CountMax) ? CountMax : int'(s);
            end
            base += sz;
          end
        end
        default: ;
      endcase
      e.managed_pages = count[16:0];
      expected_q.push_back(e);
      return e;
    endfunction

    task report(string what, rsp_t got, rsp_t exp);
      errors++;
      $display("mismatch %s: got page %0d st %0d cnt %0d, exp page %0d st %0d cnt %0d",
               what, got.alloc_page, got.status, got.managed_pages,
               exp.alloc_page, exp.status, exp.managed_pages);
    endtask

    task check_result(rsp_t got);
      rsp_t e;
      results++;
      if (expected_q.size() == 0) begin
        report("unexpected result", got, '0);
        return;
      end
      e = expected_q.pop_front();
      if (got.alloc_page !== e.alloc_page) report("alloc_page", got, e);
      if (got.status !== e.status) report("status", got, e);
      if (got.managed_pages !== e.managed_pages) report("managed_pages", got, e);
    endtask
  endclass

  logic  clk_i;
  logic  rst_ni;
  logic  start;
  logic  busy;
  req_t  req_i;
  logic  done_o;
  rsp_t  rsp_o;

  alloc_scoreboard sb;
  int    items_sent;
  int    idle_cycles;
  int    allocs_ok;
  logic [15:0] held_page[$];
  logic [3:0]  held_order[$];

  buddy_page_allocator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  // Clock generation
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Check every result strobe
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(rsp_o);
  end

  // Abort when nothing moves for too long
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchLimit) begin
      $display("timeout: %0d items pending", sb.expected_q.size());
      $display("status: fail");
      $finish;
    end
  end

  // Drive one item after a random gap and wait for acceptance
  task send_item(logic [1:0] rt, logic [3:0] ord, logic [15:0] pg, logic [16:0] endp);
    req_t r;
    rsp_t e;
    int   gap;
    r.req_type = rt;
    r.order    = ord;
    r.page     = pg;
    r.end_page = endp;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    e = sb.note_item(r);
    items_sent++;
    if (rt == ReqAlloc && ord <= MaxOrder && e.status == StOk) begin
      allocs_ok++;
      held_page.push_back(e.alloc_page);
      held_order.push_back(ord);
    end
  endtask

  // Free a block handed out earlier, picked at random
  task free_held();
    int k;
    logic [15:0] pg;
    logic [3:0]  ord;
    k = $urandom_range(0, held_page.size() - 1);
    pg = held_page[k];
    ord = held_order[k];
    held_page.delete(k);
    held_order.delete(k);
    send_item(ReqFree, ord, pg, 17'($urandom));
  endtask

  initial begin
    int n;
    int sel;
    logic [15:0] pg;
    sb = new();
    items_sent = 0;
    allocs_ok = 0;
    idle_cycles = 0;
    start = 1'b0;
    req_i = '0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty pool, bad orders, pool edges, clipping, overlaps
    send_item(ReqAlloc, 4'd0, 16'd0, 17'd0);
    send_item(ReqAlloc, 4'd11, 16'd0, 17'd0);
    send_item(ReqFree, 4'd15, 16'hFFFF, 17'h1FFFF);
    send_item(ReqFree, 4'd10, 16'hFFFF, 17'd0);
    send_item(ReqFree, 4'd3, 16'd5, 17'd0);
    send_item(ReqAdd, 4'd0, 16'd8, 17'd8);
    send_item(ReqAdd, 4'd0, 16'd3, 17'd1100);
    send_item(ReqAdd, 4'd0, 16'd16, 17'd40);
    send_item(ReqAlloc, 4'd10, 16'd0, 17'd0);
    send_item(ReqAlloc, 4'd0, 16'd0, 17'd0);
    send_item(ReqAlloc, 4'd4, 16'd0, 17'd0);
    send_item(ReqFree, 4'd2, 16'd4, 17'd0);
    send_item(ReqFree, 4'd2, 16'd4, 17'd0);
    send_item(ReqNone, 4'hF, 16'hFFFF, 17'h1FFFF);
    send_item(ReqAdd, 4'd0, 16'hFFFF, 17'h1FFFF);
    send_item(ReqFree, 4'd0, 16'hFFFF, 17'd0);
    send_item(ReqAdd, 4'hF, 16'hFC00, 17'h10000);
    send_item(ReqAlloc, 4'd10, 16'd0, 17'd0);
    send_item(ReqFree, 4'd10, 16'hFC00, 17'd0);
    send_item(ReqAdd, 4'd0, 16'd0, 17'h1FFFF);
    send_item(ReqAlloc, 4'd0, 16'd0, 17'd0);
    send_item(ReqAlloc, 4'd9, 16'd0, 17'd0);
    while (held_page.size() > 0) free_held();

    // Random: mostly alloc/free traffic in a low window, some noise
    for (n = 0; n < 1300; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 38) begin
        send_item(ReqAlloc, 4'($urandom_range(0, 3) == 0 ? $urandom_range(0, 10)
                                                         : $urandom_range(0, 3)),
                  16'($urandom), 17'($urandom));
      end else if (sel < 70 && held_page.size() > 0) begin
        free_held();
      end else if (sel < 82) begin
        pg = 16'($urandom_range(0, 8191));
        send_item(ReqAdd, 4'($urandom), pg, 17'(pg) + 17'($urandom_range(0, 700)));
      end else if (sel < 90) begin
        sel = $urandom_range(0, 6);
        send_item(ReqFree, 4'(sel), 16'($urandom_range(0, 8191)) & ~16'((1 << sel) - 1),
                  17'($urandom));
      end else begin
        send_item(2'($urandom), 4'($urandom), 16'($urandom), 17'($urandom));
      end
    end
    start <= 1'b0;

    // Drain outstanding results, then allow trailing strobes
    while (sb.expected_q.size() > 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("ran %0d items, %0d results checked, %0d successful allocations",
             items_sent, sb.results, allocs_ok);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("status: fail");
    end
    $finish;
  end

endmodule
